// ===== design/tcwpq_pkg.sv =====
// Shared types and constants for the two-class weighted priority queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package tcwpq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W      = PTR_W + 1;

	localparam int ID_W        = 16;
	localparam int AGE_W       = 8;
	localparam int CFG_W       = 8;
	localparam int STATUS_W    = 3;
	localparam int ENTRY_W     = ID_W + AGE_W;
	localparam int DATA_W      = ((ENTRY_W + 7) / 8) * 8;
	localparam int CFG_IDX_W   = 1;

	localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0]  LAST_P  = PTR_W'(QUEUE_DEPTH - 1);

	localparam logic [CFG_W-1:0] BURST_LIMIT_RST   = 8'd2;
	localparam logic [CFG_W-1:0] AGE_THRESHOLD_RST = 8'd60;

	typedef enum logic {
		CMD_ADD    = 1'b0,
		CMD_REMOVE = 1'b1
	} command_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BURST_LIMIT   = 1'b0,
		CFG_AGE_THRESHOLD = 1'b1
	} cfg_index_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED    = 3'd0,
		ST_DROPPED  = 3'd1,
		ST_REM_PRI  = 3'd2,
		ST_REM_NORM = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESULT
	} ctl_state_t;

	typedef struct packed {
		logic load_item;
		logic exec;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_stat_t;

	// Advance a ring pointer by one, wrapping at the queue depth.
	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == LAST_P) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	// Slot behind the last stored entry; fill is below the depth when called.
	function automatic logic [PTR_W-1:0] tail_ptr(input logic [PTR_W-1:0] head,
			input logic [FILL_W-1:0] fill);
		logic [FILL_W-1:0] sum;
		sum = {1'b0, head} + fill;
		if (sum >= DEPTH_F) begin
			sum = sum - DEPTH_F;
		end
		return sum[PTR_W-1:0];
	endfunction

endpackage

// ===== design/tcwpq_ctrl.sv =====
// Sequencing controller for the two-class priority queue.
// Depends on tcwpq_pkg for the state type and the command/status structs.
module tcwpq_ctrl import tcwpq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready      = 1'b0;
		cmd.load_item = 1'b0;
		cmd.exec      = 1'b0;
		cmd.load_out  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready      = 1'b1;
				cmd.load_item = s_tvalid;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
			end
			S_RESULT: begin
				cmd.load_out = stat.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

// ===== design/tcwpq_dpath.sv =====
// Datapath of the two-class priority queue: item register, both FIFO stores,
// pointers, burst counter, configuration registers and output register. Uses tcwpq_pkg.
module tcwpq_dpath import tcwpq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat,
	input  logic [DATA_W-1:0]    s_tdata,
	input  logic                 s_tuser,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [DATA_W-1:0]    m_tdata,
	output logic [STATUS_W-1:0]  m_tuser
);

	logic [CFG_W-1:0] burst_limit_q;
	logic [CFG_W-1:0] age_threshold_q;

	command_t         command_q;
	logic [ID_W-1:0]  id_q;
	logic [AGE_W-1:0] age_q;

	logic [ENTRY_W-1:0] pri_mem [QUEUE_DEPTH];
	logic [ENTRY_W-1:0] norm_mem [QUEUE_DEPTH];
	logic [ENTRY_W-1:0] pri_rd_q;
	logic [ENTRY_W-1:0] norm_rd_q;

	logic [PTR_W-1:0]  pri_head_q;
	logic [PTR_W-1:0]  norm_head_q;
	logic [FILL_W-1:0] pri_fill_q;
	logic [FILL_W-1:0] norm_fill_q;
	logic [CFG_W-1:0]  burst_q;

	status_t           status_q;
	logic              m_tvalid_q;
	logic [DATA_W-1:0] m_tdata_q;
	status_t           m_tuser_q;

	logic              to_pri;
	logic              pri_full;
	logic              norm_full;
	logic              pri_empty;
	logic              norm_empty;
	logic              normal_turn;
	logic              pri_wr;
	logic              norm_wr;
	logic [PTR_W-1:0]  pri_tail;
	logic [PTR_W-1:0]  norm_tail;
	logic [PTR_W-1:0]  pri_head_d;
	logic [PTR_W-1:0]  norm_head_d;
	logic [FILL_W-1:0] pri_fill_d;
	logic [FILL_W-1:0] norm_fill_d;
	logic [CFG_W-1:0]  burst_d;
	status_t           status_d;
	logic [ENTRY_W-1:0] out_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_limit_q   <= BURST_LIMIT_RST;
			age_threshold_q <= AGE_THRESHOLD_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_BURST_LIMIT:   burst_limit_q   <= cfg_data;
				CFG_AGE_THRESHOLD: age_threshold_q <= cfg_data;
				default:           burst_limit_q   <= burst_limit_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			command_q <= command_t'(s_tuser);
			id_q      <= s_tdata[ID_W-1:0];
			age_q     <= s_tdata[ENTRY_W-1:ID_W];
		end
	end

	assign pri_full   = (pri_fill_q == DEPTH_F);
	assign norm_full  = (norm_fill_q == DEPTH_F);
	assign pri_empty  = (pri_fill_q == '0);
	assign norm_empty = (norm_fill_q == '0);
	assign to_pri     = (age_q > age_threshold_q);
	assign pri_tail   = tail_ptr(pri_head_q, pri_fill_q);
	assign norm_tail  = tail_ptr(norm_head_q, norm_fill_q);
	assign normal_turn = (burst_q >= burst_limit_q) || pri_empty;

	// Next queue state for the item held in the item register.
	always_comb begin
		pri_wr      = 1'b0;
		norm_wr     = 1'b0;
		pri_head_d  = pri_head_q;
		norm_head_d = norm_head_q;
		pri_fill_d  = pri_fill_q;
		norm_fill_d = norm_fill_q;
		burst_d     = burst_q;
		status_d    = ST_ADDED;
		if (command_q == CMD_ADD) begin
			if (to_pri) begin
				if (pri_full) begin
					status_d = ST_DROPPED;
				end else begin
					pri_wr     = 1'b1;
					pri_fill_d = pri_fill_q + FILL_W'(1);
				end
			end else begin
				if (norm_full) begin
					status_d = ST_DROPPED;
				end else begin
					norm_wr     = 1'b1;
					norm_fill_d = norm_fill_q + FILL_W'(1);
				end
			end
		end else if (normal_turn) begin
			burst_d = '0;
			if (!norm_empty) begin
				status_d    = ST_REM_NORM;
				norm_head_d = ptr_inc(norm_head_q);
				norm_fill_d = norm_fill_q - FILL_W'(1);
			end else if (!pri_empty) begin
				status_d   = ST_REM_PRI;
				pri_head_d = ptr_inc(pri_head_q);
				pri_fill_d = pri_fill_q - FILL_W'(1);
			end else begin
				status_d = ST_EMPTY;
			end
		end else begin
			status_d   = ST_REM_PRI;
			pri_head_d = ptr_inc(pri_head_q);
			pri_fill_d = pri_fill_q - FILL_W'(1);
			burst_d    = burst_q + CFG_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pri_head_q  <= '0;
			norm_head_q <= '0;
			pri_fill_q  <= '0;
			norm_fill_q <= '0;
			burst_q     <= '0;
		end else if (cmd.exec) begin
			pri_head_q  <= pri_head_d;
			norm_head_q <= norm_head_d;
			pri_fill_q  <= pri_fill_d;
			norm_fill_q <= norm_fill_d;
			burst_q     <= burst_d;
		end
	end

	// Both stores read their head entry while the item executes; the head
	// registers still hold the old value then, so the popped entry is captured.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (pri_wr) begin
				pri_mem[pri_tail] <= {age_q, id_q};
			end
			if (norm_wr) begin
				norm_mem[norm_tail] <= {age_q, id_q};
			end
			pri_rd_q  <= pri_mem[pri_head_q];
			norm_rd_q <= norm_mem[norm_head_q];
			status_q  <= status_d;
		end
	end

	always_comb begin
		case (status_q)
			ST_REM_PRI:  out_entry = pri_rd_q;
			ST_REM_NORM: out_entry = norm_rd_q;
			default:     out_entry = '0;
		endcase
	end

	assign stat.out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			m_tdata_q <= DATA_W'(out_entry);
			m_tuser_q <= status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== design/two_class_weighted_priority_queue_unit.sv =====
// Two-class weighted priority queue: one add or remove word in, one result word out.
// Steps, set by the sequencing controller: accept the word (idle), update the queue with
// store read (execute), load the output register (result). A new word is taken only after
// the result is loaded; a stalled output holds the third step.
// Reset clears pointers, fill counts, burst counter and handshake state and loads
// the configuration defaults; the entry stores are not cleared.
module two_class_weighted_priority_queue_unit import tcwpq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [DATA_W-1:0]    s_tdata,   // entry_id [15:0], entry_age [23:16]
	input  logic                 s_tuser,   // command [0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [DATA_W-1:0]    m_tdata,   // out_id [15:0], out_age [23:16]
	output logic [STATUS_W-1:0]  m_tuser,   // status [2:0]
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	tcwpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tcwpq_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

// ===== sim/two_class_weighted_priority_queue_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the two-class weighted priority queue unit: random add/remove words
// under several burst/threshold settings, each result checked against an in-bench queue model.
// Depends on tcwpq_pkg and two_class_weighted_priority_queue_unit.
module two_class_weighted_priority_queue_unit_test;
	import tcwpq_pkg::*;

	localparam int PRI         = 0;
	localparam int NRM         = 1;
	localparam int LIMIT       = 400000;
	localparam int PHASES      = 5;
	localparam int PHASE_ITEMS = 225;
	localparam int MAX_REPORTS = 10;
	localparam int SETTLE      = 8;

	typedef struct {
		status_t          status;
		logic [ID_W-1:0]  id;
		logic [AGE_W-1:0] age;
	} result_t;

	// Tracks both FIFOs and the burst counter, and holds the results still owed by the block.
	class queue_ledger;
		logic [ENTRY_W-1:0] store [2][QUEUE_DEPTH];
		logic [PTR_W-1:0]   head [2];
		logic [FILL_W-1:0]  fill [2];
		logic [CFG_W-1:0]   burst_count;
		logic [CFG_W-1:0]   burst_limit;
		logic [CFG_W-1:0]   age_threshold;
		result_t            awaited[$];
		int unsigned        errors;

		function new();
			head[PRI] = '0;
			head[NRM] = '0;
			fill[PRI] = '0;
			fill[NRM] = '0;
			burst_count = '0;
			burst_limit = BURST_LIMIT_RST;
			age_threshold = AGE_THRESHOLD_RST;
			errors = 0;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= MAX_REPORTS) begin
				$display("mismatch at %0t: %s", $realtime, msg);
			end
		endfunction

		function result_t take(int cls, status_t st);
			result_t r;
			r.status = st;
			{r.age, r.id} = store[cls][head[cls]];
			head[cls] = PTR_W'((int'(head[cls]) + 1) % QUEUE_DEPTH);
			fill[cls] = fill[cls] - 1'b1;
			return r;
		endfunction

		// Work out the result of one accepted word and queue it.
		function void admit_word(command_t cmd, logic [ID_W-1:0] id, logic [AGE_W-1:0] age);
			result_t r;
			int      cls;
			int      slot;
			r = '{ST_ADDED, '0, '0};
			if (cmd == CMD_ADD) begin
				cls = (age > age_threshold) ? PRI : NRM;
				if (fill[cls] == FILL_W'(QUEUE_DEPTH)) begin
					r.status = ST_DROPPED;
				end else begin
					slot = (int'(head[cls]) + int'(fill[cls])) % QUEUE_DEPTH;
					store[cls][slot] = {age, id};
					fill[cls] = fill[cls] + 1'b1;
				end
			end else if (burst_count >= burst_limit || fill[PRI] == 0) begin
				// Normal turn, or nothing waiting in the priority FIFO; the turn is used up.
				burst_count = '0;
				if (fill[NRM] != 0) begin
					r = take(NRM, ST_REM_NORM);
				end else if (fill[PRI] != 0) begin
					r = take(PRI, ST_REM_PRI);
				end else begin
					r.status = ST_EMPTY;
				end
			end else begin
				r = take(PRI, ST_REM_PRI);
				burst_count = burst_count + 1'b1;
			end
			awaited.push_back(r);
		endfunction

		function void check_word(logic [STATUS_W-1:0] st, logic [ID_W-1:0] id,
				logic [AGE_W-1:0] age);
			result_t e;
			if (awaited.size() == 0) begin
				flag($sformatf("unexpected result status %0d id %h age %h", st, id, age));
				return;
			end
			e = awaited.pop_front();
			if (e.status !== st || e.id !== id || e.age !== age) begin
				flag($sformatf("expected status %0d id %h age %h, got status %0d id %h age %h",
					e.status, e.id, e.age, st, id, age));
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [DATA_W-1:0]    s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [DATA_W-1:0]    m_tdata;
	logic [STATUS_W-1:0]  m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_BURST_LIMIT;
	logic [CFG_W-1:0]     cfg_data = '0;

	queue_ledger ledger = new();
	int          send_idle_pct = 23;
	int          recv_idle_pct = 75;
	int          stall_request = 0;
	int          cycles = 0;

	two_class_weighted_priority_queue_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("two_class_weighted_priority_queue_unit_test: errors");
		$finish;
	end

	// Result side: checks each accepted word, then picks the next ready level.
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				ledger.check_word(m_tuser, m_tdata[ID_W-1:0], m_tdata[ENTRY_W-1:ID_W]);
			end
			if (stall_request > 0) begin
				hold = stall_request;
				stall_request = 0;
			end
			if (hold > 0) begin
				m_tready <= 1'b0;
				hold--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_word(command_t cmd, logic [ID_W-1:0] id, logic [AGE_W-1:0] age);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= DATA_W'({age, id});
		s_tuser <= cmd;
		do begin
			@(posedge clk);
		end while (!s_tready);
		ledger.admit_word(cmd, id, age);
	endtask

	// Stop offering words until every owed result is back, then let the pipeline settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (ledger.awaited.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic program_registers(logic [CFG_W-1:0] burst, logic [CFG_W-1:0] thr);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_BURST_LIMIT;
		cfg_data <= burst;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		ledger.burst_limit = burst;
		cfg_index <= CFG_AGE_THRESHOLD;
		cfg_data <= thr;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		ledger.age_threshold = thr;
		cfg_valid <= 1'b0;
	endtask

	// Ages cluster around the threshold and the ends of the range.
	function automatic logic [AGE_W-1:0] pick_age(logic [CFG_W-1:0] thr);
		int a;
		case ($urandom_range(3))
			0: begin
				a = int'(thr) + int'($urandom_range(2)) - 1;
			end
			1: begin
				a = $urandom_range(1) ? 255 : 0;
			end
			default: begin
				a = $urandom_range(255);
			end
		endcase
		if (a < 0) begin
			a = 0;
		end else if (a > 255) begin
			a = 255;
		end
		return AGE_W'(a);
	endfunction

	initial begin
		int add_pct;
		int seg_left;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed words under the reset settings.
		send_word(CMD_REMOVE, 16'hFFFF, 8'hFF);
		send_word(CMD_ADD, 16'h0000, 8'd0);
		send_word(CMD_ADD, 16'hFFFF, 8'd255);
		send_word(CMD_ADD, 16'h1234, 8'd60);
		send_word(CMD_ADD, 16'hABCD, 8'd61);
		repeat (5) send_word(CMD_REMOVE, ID_W'($urandom), AGE_W'($urandom));
		// Seventeen normal adds: the last one finds the FIFO full.
		for (int i = 0; i < QUEUE_DEPTH + 1; i++) begin
			send_word(CMD_ADD, ID_W'(16'h8000 | i), AGE_W'(i * 3));
		end
		drain();

		for (int p = 0; p < PHASES; p++) begin
			if (p == 2) begin
				send_idle_pct = 75;
				recv_idle_pct = 23;
			end else if (p == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (p)
				0: program_registers(8'd2, 8'd60);
				1: program_registers(8'd0, 8'd255);
				2: program_registers(8'd255, 8'd0);
				3: program_registers(8'd1, 8'd128);
				default: program_registers(CFG_W'($urandom_range(255)),
					CFG_W'($urandom_range(255)));
			endcase
			// Long output stall while words keep coming, so the input backs up.
			if (p == 2) begin
				stall_request = 200;
			end
			seg_left = 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (seg_left == 0) begin
					case ($urandom_range(2))
						0: add_pct = 15;
						1: add_pct = 50;
						default: add_pct = 85;
					endcase
					seg_left = $urandom_range(40, 10);
				end
				seg_left--;
				if (n == PHASE_ITEMS / 2) begin
					drain();
				end
				if ($urandom_range(99) < add_pct) begin
					send_word(CMD_ADD, ID_W'($urandom), pick_age(ledger.age_threshold));
				end else begin
					send_word(CMD_REMOVE, ID_W'($urandom), AGE_W'($urandom));
				end
			end
			drain();
		end

		if (ledger.awaited.size() != 0) begin
			ledger.flag($sformatf("%0d results never arrived", ledger.awaited.size()));
		end
		if (ledger.errors == 0) begin
			$display("two_class_weighted_priority_queue_unit_test: clean");
		end else begin
			$display("two_class_weighted_priority_queue_unit_test: errors");
		end
		$finish;
	end

endmodule

// ===== two_class_weighted_priority_queue_unit.f =====
design/tcwpq_pkg.sv
design/tcwpq_ctrl.sv
design/tcwpq_dpath.sv
design/two_class_weighted_priority_queue_unit.sv
sim/two_class_weighted_priority_queue_unit_test.sv
